>>> design/ordered_list_insert_erase_macros.svh
// Assertion macros used by the ordered list datapath (oli_dpath).
// Include this header by its bare file name; it depends on nothing else.
`ifndef ORDERED_LIST_INSERT_ERASE_MACROS_SVH
`define ORDERED_LIST_INSERT_ERASE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define OLI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define OLI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/oli_pkg.sv
// Package for the ordered list block: field widths, operation and status codes,
// and the command and status structs between controller and datapath. No dependencies.
package oli_pkg;

   localparam int OP_W   = 3;
   localparam int POS_W  = 7;
   localparam int DATA_W = 32;
   localparam int ST_W   = 2;
   localparam int CNT_W  = 7;

   localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
   localparam logic [OP_W-1:0] OP_ERASE  = 3'd2;
   localparam logic [OP_W-1:0] OP_POP    = 3'd3;
   localparam logic [OP_W-1:0] OP_READ   = 3'd4;

   localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
   localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
   localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

   // Source of the read address.
   typedef enum logic [1:0] {
      RA_POS,
      RA_PREV,
      RA_NEXT
   } raddr_sel_type;

   // Update of the shift index.
   typedef enum logic [2:0] {
      IDX_HOLD,
      IDX_COUNT,
      IDX_POS,
      IDX_DEC,
      IDX_INC
   } idx_op_type;

   // Source of the result word.
   typedef enum logic [1:0] {
      RES_ZERO,
      RES_ONES,
      RES_MEM
   } res_sel_type;

   typedef struct packed {
      logic          load_item;
      idx_op_type    idx_op;
      logic          mem_we;
      logic          waddr_count;
      logic          wdata_mem;
      logic          mem_re;
      raddr_sel_type raddr_sel;
      logic          cnt_inc;
      logic          cnt_dec;
      logic          rsp_load;
      res_sel_type   res_sel;
      logic [ST_W-1:0] res_status;
   } oli_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            full;
      logic            empty;
      logic            ins_range;
      logic            pos_ge_count;
      logic            idx_at_pos;
      logic            erase_done;
      logic            rsp_free;
   } oli_sts_type;

endpackage

>>> design/oli_if.sv
// Valid/ready channel interfaces for the request and response beats.
// Depends on oli_pkg for the field widths.
interface oli_req_if import oli_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          operation;
   logic [POS_W-1:0]         position;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, output operation, output position, output value,
                   input ready);
   modport sink (input valid, input operation, input position, input value,
                 output ready);
endinterface

interface oli_rsp_if import oli_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] read_value;
   logic [ST_W-1:0]          status;
   logic [CNT_W-1:0]         entry_count;

   modport source (output valid, output read_value, output status, output entry_count,
                   input ready);
   modport sink (input valid, input read_value, input status, input entry_count,
                 output ready);
endinterface

>>> design/ordered_list_insert_erase.sv
// Ordered list of signed 32-bit words: top level joining controller and datapath.
// Depends on oli_pkg, oli_if (channel interfaces), oli_ctrl and oli_dpath.
//
// The block keeps an ordered list of up to CAPACITY signed words with a count
// of entries in use. Each request beat carries one operation: append, insert
// at a position (later entries move up), erase at a position (later entries
// move down), remove the last entry, or read an entry. Each request yields
// exactly one response beat with the word read (-1 on a failed read, zero
// otherwise), a status (done, store full, or position out of range / list
// empty) and the count after the operation. Refused operations change nothing.
// The block handles one request at a time. Append, remove, read, every refused
// operation and unused codes settle in the evaluation state before the response
// register is loaded. A good insert or erase then moves later entries one by one,
// insert from the last entry down and erase from the position up: the entries
// are held in one memory with a single read port, a single write port and
// registered read data, so every entry that moves is first read, then written.
// A new request is taken as soon as the previous one has reached the response
// register, even while that response waits for the sink. Entries need no
// clearing after reset; only entries below the count are ever read.

module ordered_list_insert_erase import oli_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input logic       clock,
   input logic       reset,
   oli_req_if.sink   req_chan,
   oli_rsp_if.source rsp_chan
);

   oli_cmd_type cmd;
   oli_sts_type sts;

   // The controller sequences each operation, including the entry-by-entry
   // shift of an insert or erase, and holds the result status until the
   // response register is free.
   oli_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath owns the entry memory, the count, the shift index and the
   // response register that parts the request side from the response side.
   oli_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_operation   (req_chan.operation),
      .req_position    (req_chan.position),
      .req_value       (req_chan.value),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_read_value  (rsp_chan.read_value),
      .rsp_status      (rsp_chan.status),
      .rsp_entry_count (rsp_chan.entry_count)
   );

endmodule

>>> design/oli_ctrl.sv
// Controller state machine of the ordered list block.
// Depends on oli_pkg; drives the datapath through oli_cmd_type only.
module oli_ctrl import oli_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  oli_sts_type sts,
   output oli_cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL,
      S_INS_CHK,
      S_INS_WR,
      S_ERS_CHK,
      S_ERS_WR,
      S_FINISH
   } state_type;

   state_type       state_ff, state_in;
   logic [ST_W-1:0] res_status_ff, res_status_in;
   res_sel_type     res_sel_ff, res_sel_in;

   always_comb begin
      state_in      = state_ff;
      res_status_in = res_status_ff;
      res_sel_in    = res_sel_ff;
      req_ready     = 1'b0;

      cmd.load_item   = 1'b0;
      cmd.idx_op      = IDX_HOLD;
      cmd.mem_we      = 1'b0;
      cmd.waddr_count = 1'b0;
      cmd.wdata_mem   = 1'b0;
      cmd.mem_re      = 1'b0;
      cmd.raddr_sel   = RA_POS;
      cmd.cnt_inc     = 1'b0;
      cmd.cnt_dec     = 1'b0;
      cmd.rsp_load    = 1'b0;
      cmd.res_sel     = res_sel_ff;
      cmd.res_status  = res_status_ff;

      case (state_ff)
         S_IDLE: begin
            // No beat is taken while reset is held.
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.load_item = 1'b1;
               state_in      = S_EVAL;
            end
         end
         S_EVAL: begin
            // Most operations settle here; only a good insert or erase walks the store.
            state_in      = S_FINISH;
            res_status_in = ST_DONE;
            res_sel_in    = RES_ZERO;
            case (sts.op)
               OP_APPEND: begin
                  if (sts.full) begin
                     res_status_in = ST_FULL;
                  end else begin
                     cmd.mem_we      = 1'b1;
                     cmd.waddr_count = 1'b1;
                     cmd.cnt_inc     = 1'b1;
                  end
               end
               OP_INSERT: begin
                  if (sts.full) begin
                     res_status_in = ST_FULL;
                  end else if (sts.ins_range) begin
                     res_status_in = ST_RANGE;
                  end else begin
                     cmd.idx_op = IDX_COUNT;
                     state_in   = S_INS_CHK;
                  end
               end
               OP_ERASE: begin
                  if (sts.pos_ge_count) begin
                     res_status_in = ST_RANGE;
                  end else begin
                     cmd.idx_op = IDX_POS;
                     state_in   = S_ERS_CHK;
                  end
               end
               OP_POP: begin
                  if (sts.empty) begin
                     res_status_in = ST_RANGE;
                  end else begin
                     cmd.cnt_dec = 1'b1;
                  end
               end
               OP_READ: begin
                  if (sts.pos_ge_count) begin
                     res_status_in = ST_RANGE;
                     res_sel_in    = RES_ONES;
                  end else begin
                     cmd.mem_re    = 1'b1;
                     cmd.raddr_sel = RA_POS;
                     res_sel_in    = RES_MEM;
                  end
               end
               default: begin
                  res_status_in = ST_DONE;
               end
            endcase
         end
         S_INS_CHK: begin
            if (sts.idx_at_pos) begin
               cmd.mem_we    = 1'b1;
               cmd.cnt_inc   = 1'b1;
               res_status_in = ST_DONE;
               res_sel_in    = RES_ZERO;
               state_in      = S_FINISH;
            end else begin
               cmd.mem_re    = 1'b1;
               cmd.raddr_sel = RA_PREV;
               state_in      = S_INS_WR;
            end
         end
         S_INS_WR: begin
            cmd.mem_we    = 1'b1;
            cmd.wdata_mem = 1'b1;
            cmd.idx_op    = IDX_DEC;
            state_in      = S_INS_CHK;
         end
         S_ERS_CHK: begin
            if (sts.erase_done) begin
               cmd.cnt_dec   = 1'b1;
               res_status_in = ST_DONE;
               res_sel_in    = RES_ZERO;
               state_in      = S_FINISH;
            end else begin
               cmd.mem_re    = 1'b1;
               cmd.raddr_sel = RA_NEXT;
               state_in      = S_ERS_WR;
            end
         end
         S_ERS_WR: begin
            cmd.mem_we    = 1'b1;
            cmd.wdata_mem = 1'b1;
            cmd.idx_op    = IDX_INC;
            state_in      = S_ERS_CHK;
         end
         S_FINISH: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         res_status_ff <= ST_DONE;
         res_sel_ff    <= RES_ZERO;
      end else begin
         state_ff      <= state_in;
         res_status_ff <= res_status_in;
         res_sel_ff    <= res_sel_in;
      end
   end

endmodule

>>> design/oli_dpath.sv
// Datapath of the ordered list block: entry memory, count, shift index and
// response register. Depends on oli_pkg and the assertion macro header.
`include "ordered_list_insert_erase_macros.svh"

module oli_dpath import oli_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [OP_W-1:0]          req_operation,
   input  logic [POS_W-1:0]         req_position,
   input  logic signed [DATA_W-1:0] req_value,
   input  oli_cmd_type              cmd,
   output oli_sts_type              sts,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_read_value,
   output logic [ST_W-1:0]          rsp_status,
   output logic [CNT_W-1:0]         rsp_entry_count
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int MW = (CW > POS_W) ? CW : POS_W;

   logic [OP_W-1:0]   op_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [DATA_W-1:0] val_ff;
   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic [DATA_W-1:0] rdata_ff;
   logic [DATA_W-1:0] mem [CAPACITY];

   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_value_ff;
   logic [ST_W-1:0]   rsp_status_ff;
   logic [CNT_W-1:0]  rsp_count_ff;

   logic [AW-1:0]     raddr;
   logic [AW-1:0]     waddr;
   logic [DATA_W-1:0] wdata;
   logic [MW-1:0]     pos_ext;
   logic [MW-1:0]     count_ext;
   logic [MW-1:0]     idx_ext;
   logic              rsp_free;

   assign pos_ext   = MW'(pos_ff);
   assign count_ext = MW'(count_ff);
   assign idx_ext   = MW'(idx_ff);
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      sts.op           = op_ff;
      sts.full         = (count_ff == CW'(CAPACITY));
      sts.empty        = (count_ff == '0);
      sts.ins_range    = (pos_ext > count_ext);
      sts.pos_ge_count = (pos_ext >= count_ext);
      sts.idx_at_pos   = (idx_ext == pos_ext);
      sts.erase_done   = ((CW'(idx_ff) + CW'(1)) >= count_ff);
      sts.rsp_free     = rsp_free;
   end

   always_comb begin
      case (cmd.raddr_sel)
         RA_POS:  raddr = AW'(pos_ff);
         RA_PREV: raddr = idx_ff - AW'(1);
         RA_NEXT: raddr = idx_ff + AW'(1);
         default: raddr = AW'(pos_ff);
      endcase
      waddr = cmd.waddr_count ? AW'(count_ff) : idx_ff;
      wdata = cmd.wdata_mem ? rdata_ff : val_ff;
   end

   always_comb begin
      case (cmd.idx_op)
         IDX_HOLD:  idx_in = idx_ff;
         IDX_COUNT: idx_in = AW'(count_ff);
         IDX_POS:   idx_in = AW'(pos_ff);
         IDX_DEC:   idx_in = idx_ff - AW'(1);
         IDX_INC:   idx_in = idx_ff + AW'(1);
         default:   idx_in = idx_ff;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Entry store: one write port, one read port with registered data.
   always_ff @(posedge clock) begin
      if (cmd.mem_we) begin
         mem[waddr] <= wdata;
      end
      if (cmd.mem_re) begin
         rdata_ff <= mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff  <= req_operation;
         pos_ff <= req_position;
         val_ff <= $unsigned(req_value);
      end
      idx_ff <= idx_in;
      if (cmd.rsp_load) begin
         case (cmd.res_sel)
            RES_ZERO: rsp_value_ff <= '0;
            RES_ONES: rsp_value_ff <= '1;
            RES_MEM:  rsp_value_ff <= rdata_ff;
            default:  rsp_value_ff <= '0;
         endcase
         rsp_status_ff <= cmd.res_status;
         rsp_count_ff  <= CNT_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = $signed(rsp_value_ff);
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;

   `OLI_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(CAPACITY),
      "entry count exceeds capacity")
   `OLI_ASSERT_NOW(a_no_overwrite, clock, reset, cmd.rsp_load, rsp_free,
      "response register loaded while a beat is still waiting")
   `OLI_ASSERT_NEXT(a_count_step, clock, reset, cmd.cnt_inc,
      count_ff == $past(count_ff) + CW'(1), "count did not step up by one")
   `OLI_ASSERT_NOW(a_waddr_bound, clock, reset, cmd.mem_we, 32'(waddr) < 32'(CAPACITY),
      "entry write beyond capacity")

endmodule
